[hdl/jsu_pkg.sv]
// jsu_pkg: shared types, constants and helper functions of the json string unescaper
// no dependencies
package jsu_pkg;

  localparam int HOLD_DEPTH = 12;
  localparam int OBUF_DEPTH = 12;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // escape positions inside the held bytes
  localparam logic [3:0] POS_U_CHAR     = 4'd1;
  localparam logic [3:0] POS_HEX_START  = 4'd2;
  localparam logic [3:0] POS_FIRST_LAST = 4'd5;
  localparam logic [3:0] POS_SECOND_BSL = 4'd6;
  localparam logic [3:0] POS_SECOND_U   = 4'd7;
  localparam logic [3:0] POS_LAST       = 4'd11;

  localparam logic [4:0] HEX_BAD = 5'd16;

  // top six bits of 0xD800 and 0xDC00
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  localparam logic [1:0] UTF_CONT  = 2'b10;
  localparam logic [2:0] UTF_LEAD2 = 3'b110;
  localparam logic [3:0] UTF_LEAD3 = 4'b1110;
  localparam logic [4:0] UTF_LEAD4 = 5'b11110;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_UNI,
    MODE_PASS
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_UTF,
    ST_FLUSH,
    ST_WRAP,
    ST_DRAIN
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_UTF,
    ACT_FAIL1,
    ACT_FAIL2
  } act_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic feed;
    logic utf_push;
    logic flush_push;
    logic finish;
    logic drain_load;
  } dp_cmd_t;

  typedef struct packed {
    act_e act;
    logic utf_done;
    logic flush_done;
    logic replay_on;
    logic last;
    logic need_flush;
    logic buf_empty;
    logic drain_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // {hit, mapped byte} for the single-byte escapes
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22:   r = {1'b1, 8'h22};   // quote
      8'h5C:   r = {1'b1, 8'h5C};   // backslash
      8'h2F:   r = {1'b1, 8'h2F};   // slash
      8'h62:   r = {1'b1, 8'h08};   // b
      8'h66:   r = {1'b1, 8'h0C};   // f
      8'h6E:   r = {1'b1, 8'h0A};   // n
      8'h72:   r = {1'b1, 8'h0D};   // r
      8'h74:   r = {1'b1, 8'h09};   // t
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // index of the last utf-8 byte for a code point
  function automatic logic [1:0] utf8_last(input logic [20:0] cp);
    logic [1:0] r;
    if (cp < 21'h80) r = 2'd0;
    else if (cp < 21'h800) r = 2'd1;
    else if (cp < SUPP_BASE) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] ulast,
                                           input logic [1:0] k);
    logic [7:0] r;
    case (ulast)
      2'd0: r = cp[7:0];
      2'd1: r = (k == 2'd0) ? {UTF_LEAD2, cp[10:6]} : {UTF_CONT, cp[5:0]};
      2'd2: begin
        case (k)
          2'd0:    r = {UTF_LEAD3, cp[15:12]};
          2'd1:    r = {UTF_CONT, cp[11:6]};
          default: r = {UTF_CONT, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    r = {UTF_LEAD4, cp[20:18]};
          2'd1:    r = {UTF_CONT, cp[17:12]};
          2'd2:    r = {UTF_CONT, cp[11:6]};
          default: r = {UTF_CONT, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

[hdl/jsu_in_if.sv]
// jsu_in_if: valid/ready channel carrying raw string bytes
// depends on jsu_pkg
interface jsu_in_if;
  import jsu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[hdl/jsu_out_if.sv]
// jsu_out_if: valid/ready channel carrying decoded bytes and end markers
// depends on jsu_pkg
interface jsu_out_if;
  import jsu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[hdl/json_string_unescape.sv]
// json_string_unescape: top level, state machine plus datapath; uses jsu_pkg and the channel ifs
// per item: taken in idle, each byte fed is decoded, then any utf-8 burst or raw flush
//   (a broken surrogate pair re-feeds up to six held bytes), a cut-off escape is flushed raw,
//   then results move to the output register, or a bare end marker if a string ends with none
// one decode unit; the buffer drains one entry per cycle while the output register is free
// reset: decoder back to plain text, codes and counts zero, held bytes undefined until written
module json_string_unescape (
  input logic       clk_i,
  input logic       rst_ni,
  jsu_in_if.sink    in_ch_i,
  jsu_out_if.source out_ch_o
);
  import jsu_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  // sequencer: takes one item in idle, walks it through decode, utf-8 output, flush and drain
  jsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: escape state, held bytes, result buffer, output register
  jsu_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_ch_i.payload),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  // the output register lets a new item in while the last result waits
  assign in_ch_i.ready    = in_ready;
  assign out_ch_o.valid   = out_valid;
  assign out_ch_o.payload = out_item;

endmodule

[hdl/jsu_ctrl.sv]
// jsu_ctrl: sequencer of the unescaper, issues datapath commands per state
// depends on jsu_pkg
module jsu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jsu_pkg::dp_stat_t stat_i,
  output jsu_pkg::dp_cmd_t  cmd_o
);
  import jsu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FEED;
      end
      ST_FEED: begin
        if (stat_i.act == ACT_UTF) begin
          state_d = ST_UTF;
        end else if (stat_i.act == ACT_FAIL1 || stat_i.act == ACT_FAIL2) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_WRAP;
        end
      end
      ST_UTF: begin
        if (stat_i.utf_done) state_d = ST_WRAP;
      end
      ST_FLUSH: begin
        if (stat_i.flush_done) state_d = ST_WRAP;
      end
      ST_WRAP: begin
        if (stat_i.replay_on) begin
          state_d = ST_FEED;
        end else if (stat_i.last && stat_i.need_flush) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat_i.buf_empty && !stat_i.last) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free && stat_i.drain_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_FEED:  cmd_o.feed = 1'b1;
      ST_UTF:   cmd_o.utf_push = 1'b1;
      ST_FLUSH: cmd_o.flush_push = 1'b1;
      ST_WRAP:  cmd_o.finish = !stat_i.replay_on && stat_i.last;
      ST_DRAIN: begin
        cmd_o.drain_load = stat_i.out_free && !(stat_i.buf_empty && !stat_i.last);
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[hdl/jsu_datapath.sv]
// jsu_datapath: decode state, held escape bytes, result buffer and output register
// depends on jsu_pkg
module jsu_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsu_pkg::dp_cmd_t   cmd_i,
  output jsu_pkg::dp_stat_t  stat_o,
  input  jsu_pkg::in_item_t  in_item_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output jsu_pkg::out_item_t out_item_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [15:0] first_q, first_d;
  logic [15:0] second_q, second_d;
  logic [3:0]  hold_q, hold_d;
  logic [2:0]  pass_q, pass_d;

  logic [7:0]  raw_q  [HOLD_DEPTH];
  logic [7:0]  obuf_q [OBUF_DEPTH];

  logic [7:0]  cur_q;
  logic        last_q;
  logic        rp_on_q;
  logic [3:0]  rp_idx_q, rp_end_q;
  logic [3:0]  fl_idx_q, fl_end_q;
  logic [20:0] cp_q;
  logic [1:0]  ulast_q, uk_q;
  logic [3:0]  oc_q, dr_idx_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [3:0]  rd_idx;
  logic [7:0]  rd_byte;
  logic [7:0]  fb;
  logic [4:0]  hv;
  logic        is_hex;
  logic [15:0] fc_new, sc_new;
  logic [8:0]  esc;
  logic [3:0]  pass_sub;
  logic [20:0] cp_pair;
  act_e        act;
  logic [7:0]  em_byte;
  logic        wr_en;
  logic [3:0]  wr_idx;
  logic [20:0] cp_new;
  logic        push;
  logic [7:0]  push_byte;
  logic [3:0]  oc_m1;
  logic        dr_last;
  logic        need_flush;
  logic [3:0]  hold_m1;
  out_item_t   load_item;

  // one read port on the held bytes: flush index or replay index
  assign rd_idx  = cmd_i.flush_push ? fl_idx_q : rp_idx_q;
  assign rd_byte = raw_q[rd_idx];
  assign fb      = rp_on_q ? rd_byte : cur_q;

  assign hv       = hex_value(fb);
  assign is_hex   = ~hv[4];
  assign fc_new   = {first_q[11:0], hv[3:0]};
  assign sc_new   = {second_q[11:0], hv[3:0]};
  assign esc      = simple_escape(fb);
  assign pass_sub = POS_FIRST_LAST - hold_q;
  assign cp_pair  = {1'b0, first_q[9:0], sc_new[9:0]} + SUPP_BASE;

  // decode of the fed byte
  always_comb begin
    act      = ACT_NONE;
    em_byte  = fb;
    mode_d   = mode_q;
    hold_d   = hold_q;
    first_d  = first_q;
    second_d = second_q;
    pass_d   = pass_q;
    wr_en    = 1'b0;
    wr_idx   = hold_q;
    cp_new   = {5'd0, fc_new};
    unique case (mode_q)
      MODE_PASS: begin
        act    = ACT_EMIT;
        pass_d = (pass_q != 3'd0) ? pass_q - 3'd1 : 3'd0;
        if (pass_d == 3'd0) mode_d = MODE_PLAIN;
      end
      MODE_ESC: begin
        mode_d   = MODE_PLAIN;
        hold_d   = 4'd0;
        first_d  = 16'd0;
        second_d = 16'd0;
        if (fb == CH_U) begin
          wr_en  = 1'b1;
          wr_idx = POS_U_CHAR;
          hold_d = POS_HEX_START;
          mode_d = MODE_UNI;
        end else if (esc[8]) begin
          act     = ACT_EMIT;
          em_byte = esc[7:0];
        end
      end
      MODE_UNI: begin
        if (hold_q < POS_HEX_START || hold_q > POS_LAST) begin
          act      = ACT_EMIT;
          mode_d   = MODE_PLAIN;
          hold_d   = 4'd0;
          first_d  = 16'd0;
          second_d = 16'd0;
        end else begin
          wr_en = 1'b1;
          if (hold_q <= POS_FIRST_LAST) begin
            if (!is_hex) begin
              // first escape broken: raw out, then pass the rest of six bytes
              act      = ACT_FAIL1;
              mode_d   = MODE_PLAIN;
              hold_d   = 4'd0;
              first_d  = 16'd0;
              second_d = 16'd0;
              if (hold_q < POS_FIRST_LAST) begin
                pass_d = pass_sub[2:0];
                mode_d = MODE_PASS;
              end
            end else begin
              first_d = fc_new;
              hold_d  = hold_q + 4'd1;
              if (hold_q == POS_FIRST_LAST && fc_new[15:10] != SURR_HIGH_TAG) begin
                act      = ACT_UTF;
                mode_d   = MODE_PLAIN;
                hold_d   = 4'd0;
                first_d  = 16'd0;
                second_d = 16'd0;
              end
            end
          end else begin
            act = ACT_FAIL2;
            if (hold_q == POS_SECOND_BSL) begin
              if (fb == CH_BSLASH) begin
                act    = ACT_NONE;
                hold_d = POS_SECOND_U;
              end
            end else if (hold_q == POS_SECOND_U) begin
              if (fb == CH_U) begin
                act    = ACT_NONE;
                hold_d = hold_q + 4'd1;
              end
            end else if (is_hex) begin
              act      = ACT_NONE;
              second_d = sc_new;
              hold_d   = hold_q + 4'd1;
              if (hold_q == POS_LAST) begin
                if (sc_new[15:10] == SURR_LOW_TAG) begin
                  act    = ACT_UTF;
                  cp_new = cp_pair;
                end else begin
                  act = ACT_FAIL2;
                end
              end
            end
            if (act == ACT_FAIL2 || act == ACT_UTF) begin
              mode_d   = MODE_PLAIN;
              hold_d   = 4'd0;
              first_d  = 16'd0;
              second_d = 16'd0;
            end
          end
        end
      end
      default: begin
        if (fb == CH_BSLASH) begin
          wr_en  = 1'b1;
          wr_idx = 4'd0;
          hold_d = 4'd1;
          mode_d = MODE_ESC;
        end else begin
          act = ACT_EMIT;
        end
      end
    endcase
  end

  assign push = (cmd_i.feed && act == ACT_EMIT) || cmd_i.utf_push || cmd_i.flush_push;
  assign push_byte = cmd_i.utf_push   ? utf8_byte(cp_q, ulast_q, uk_q) :
                     cmd_i.flush_push ? rd_byte : em_byte;

  assign need_flush = (mode_q == MODE_ESC) || (mode_q == MODE_UNI);
  assign hold_m1    = hold_q - 4'd1;
  assign oc_m1      = oc_q - 4'd1;
  assign dr_last    = (oc_q == 4'd0) || (dr_idx_q == oc_m1);

  always_comb begin
    if (oc_q == 4'd0) begin
      load_item.out_byte   = 8'd0;
      load_item.byte_valid = 1'b0;
      load_item.string_end = last_q;
      load_item.run_end    = 1'b1;
    end else begin
      load_item.out_byte   = obuf_q[dr_idx_q];
      load_item.byte_valid = 1'b1;
      load_item.string_end = dr_last & last_q;
      load_item.run_end    = dr_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PLAIN;
      first_q     <= 16'd0;
      second_q    <= 16'd0;
      hold_q      <= 4'd0;
      pass_q      <= 3'd0;
      last_q      <= 1'b0;
      rp_on_q     <= 1'b0;
      rp_idx_q    <= 4'd0;
      rp_end_q    <= 4'd0;
      fl_idx_q    <= 4'd0;
      fl_end_q    <= 4'd0;
      ulast_q     <= 2'd0;
      uk_q        <= 2'd0;
      oc_q        <= 4'd0;
      dr_idx_q    <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        last_q   <= in_item_i.in_last;
        oc_q     <= 4'd0;
        dr_idx_q <= 4'd0;
        rp_on_q  <= 1'b0;
      end
      if (cmd_i.feed) begin
        mode_q   <= mode_d;
        first_q  <= first_d;
        second_q <= second_d;
        hold_q   <= hold_d;
        pass_q   <= pass_d;
        if (act == ACT_UTF) begin
          uk_q    <= 2'd0;
          ulast_q <= utf8_last(cp_new);
        end
        if (act == ACT_FAIL1) begin
          fl_idx_q <= 4'd0;
          fl_end_q <= hold_q;
        end
        if (act == ACT_FAIL2) begin
          // six raw bytes out, then the later held bytes go back in
          fl_idx_q <= 4'd0;
          fl_end_q <= POS_FIRST_LAST;
          rp_on_q  <= 1'b1;
          rp_idx_q <= POS_SECOND_BSL;
          rp_end_q <= hold_q;
        end else if (rp_on_q) begin
          if (rp_idx_q == rp_end_q) rp_on_q <= 1'b0;
          else rp_idx_q <= rp_idx_q + 4'd1;
        end
      end
      if (cmd_i.utf_push) uk_q <= uk_q + 2'd1;
      if (cmd_i.flush_push) fl_idx_q <= fl_idx_q + 4'd1;
      if (cmd_i.finish) begin
        mode_q   <= MODE_PLAIN;
        first_q  <= 16'd0;
        second_q <= 16'd0;
        hold_q   <= 4'd0;
        pass_q   <= 3'd0;
        if (need_flush) begin
          fl_idx_q <= 4'd0;
          fl_end_q <= hold_m1;
        end
      end
      if (push) oc_q <= oc_q + 4'd1;
      if (cmd_i.drain_load) dr_idx_q <= dr_idx_q + 4'd1;
      out_valid_q <= cmd_i.drain_load | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) cur_q <= in_item_i.in_byte;
    if (cmd_i.feed && act == ACT_UTF) cp_q <= cp_new;
    if (cmd_i.feed && wr_en) raw_q[wr_idx] <= fb;
    if (push) obuf_q[oc_q] <= push_byte;
    if (cmd_i.drain_load) out_q <= load_item;
  end

  assign stat_o.act        = act;
  assign stat_o.utf_done   = (uk_q == ulast_q);
  assign stat_o.flush_done = (fl_idx_q == fl_end_q);
  assign stat_o.replay_on  = rp_on_q;
  assign stat_o.last       = last_q;
  assign stat_o.need_flush = need_flush;
  assign stat_o.buf_empty  = (oc_q == 4'd0);
  assign stat_o.drain_done = dr_last;
  assign stat_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[bench/tb_json_string_unescape.sv]
// tb_json_string_unescape: self-checking bench for the json string unescaper
// needs jsu_pkg, jsu_in_if, jsu_out_if and json_string_unescape from hdl
`timescale 1ns / 100ps

module tb_json_string_unescape;
  import jsu_pkg::*;

  localparam int RUN_MAX     = 12;   // most results one input byte can cause
  localparam int IDLE_PCT    = 19;
  localparam int HOLD_CYCLES = 120;  // long receiver hold-off
  localparam int TAIL_CYCLES = 50;   // settle time after the last result
  localparam int RAND_ITEMS  = 100;

  // characters of the escape grammar
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_ONE   = 8'h31;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // unescape predictor: its own copy of the decoder state
  // ---------------------------------------------------------------------------
  mode_e       dec_mode;
  logic [15:0] code_hi;            // first \u value
  logic [15:0] code_lo;            // second \u value of a surrogate pair
  logic [7:0]  held [HOLD_DEPTH];  // raw bytes of the escape in progress
  int unsigned held_n;
  logic [2:0]  pass_left;          // raw bytes still to pass after a bad first escape

  logic [7:0]  emit_q[$];          // bytes produced by the current input byte
  logic [7:0]  work_q[$];          // bytes to decode, the new one plus any re-fed ones
  out_item_t   decoded_q[$];       // expected results, oldest first

  function void esc_clear();
    dec_mode = MODE_PLAIN;
    held_n   = 0;
    code_hi  = '0;
    code_lo  = '0;
  endfunction

  function void model_reset();
    esc_clear();
    pass_left = '0;
    for (int i = 0; i < HOLD_DEPTH; i++) held[i] = '0;
    decoded_q.delete();
  endfunction

  function automatic logic [4:0] nib(logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    return v;
  endfunction

  function void emit(logic [7:0] b);
    emit_q.push_back(b);
  endfunction

  function void emit_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]});
      emit({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end else begin
      emit({5'b11110, cp[20:18]});
      emit({2'b10, cp[17:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end
  endfunction

  // broken pair: first escape goes out raw, the rest is decoded again
  function void break_pair(int unsigned pos);
    for (int i = 0; i < 6; i++) emit(held[i]);
    for (int i = 6; i <= pos && i < HOLD_DEPTH; i++) work_q.push_back(held[i]);
    esc_clear();
  endfunction

  function void uni_byte(logic [7:0] b);
    int unsigned pos;
    logic [4:0]  v;
    int unsigned cp;
    pos = held_n;
    if (pos < 2 || pos >= HOLD_DEPTH) begin
      esc_clear();
      emit(b);
      return;
    end
    held[pos] = b;
    if (pos <= 5) begin
      v = nib(b);
      if (v[4]) begin
        for (int i = 0; i <= pos; i++) emit(held[i]);
        esc_clear();
        if (pos < 5) begin
          pass_left = 3'(5 - pos);
          dec_mode  = MODE_PASS;
        end
        return;
      end
      code_hi = {code_hi[11:0], v[3:0]};
      held_n  = pos + 1;
      if (pos == 5 && !(code_hi >= 16'hD800 && code_hi <= 16'hDBFF)) begin
        emit_utf8({5'd0, code_hi});
        esc_clear();
      end
      return;
    end
    if (pos == 6) begin
      if (b != CH_BSLASH) break_pair(pos);
      else held_n = 7;
      return;
    end
    if (pos == 7) begin
      if (b != CH_U) break_pair(pos);
      else held_n = 8;
      return;
    end
    v = nib(b);
    if (v[4]) begin
      break_pair(pos);
      return;
    end
    code_lo = {code_lo[11:0], v[3:0]};
    held_n  = pos + 1;
    if (pos == 11) begin
      if (code_lo >= 16'hDC00 && code_lo <= 16'hDFFF) begin
        cp = ((int'(code_hi) - 32'hD800) << 10) + (int'(code_lo) - 32'hDC00) + 32'h10000;
        emit_utf8(cp[20:0]);
        esc_clear();
      end else begin
        break_pair(pos);
      end
    end
  endfunction

  function void feed_byte(logic [7:0] b);
    case (dec_mode)
      MODE_PASS: begin
        emit(b);
        if (pass_left > 0) pass_left = pass_left - 3'd1;
        if (pass_left == 0) dec_mode = MODE_PLAIN;
      end
      MODE_ESC: begin
        esc_clear();
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: emit(b);
          CH_LB: emit(8'h08);
          CH_LF: emit(8'h0C);
          CH_LN: emit(8'h0A);
          CH_LR: emit(8'h0D);
          CH_LT: emit(8'h09);
          CH_U: begin
            held[0]  = CH_BSLASH;
            held[1]  = CH_U;
            held_n   = 2;
            dec_mode = MODE_UNI;
          end
          default: ;  // unknown escape is dropped
        endcase
      end
      MODE_UNI: uni_byte(b);
      default: begin
        if (b == CH_BSLASH) begin
          held[0]  = b;
          held_n   = 1;
          dec_mode = MODE_ESC;
        end else begin
          emit(b);
        end
      end
    endcase
  endfunction

  // works out every result one accepted input item causes
  function void unescape_item(in_item_t it);
    out_item_t   r;
    int unsigned n;
    emit_q.delete();
    work_q.delete();
    work_q.push_back(it.in_byte);
    while (work_q.size() > 0) feed_byte(work_q.pop_front());
    if (it.in_last) begin
      // cut-off escape goes out raw, a running pass-through just stops
      if (dec_mode == MODE_ESC || dec_mode == MODE_UNI)
        for (int i = 0; i < held_n; i++) emit(held[i]);
      esc_clear();
      pass_left = '0;
    end
    n = (emit_q.size() < RUN_MAX) ? emit_q.size() : RUN_MAX;
    if (n == 0) begin
      if (it.in_last) begin
        // bare end marker
        r = '{out_byte: 8'h00, byte_valid: 1'b0, string_end: 1'b1, run_end: 1'b1};
        decoded_q.push_back(r);
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        r.out_byte   = emit_q[k];
        r.byte_valid = 1'b1;
        r.string_end = it.in_last && (k == n - 1);
        r.run_end    = (k == n - 1);
        decoded_q.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: drives raw bytes from the pending queue, predicts at each accept
  // ---------------------------------------------------------------------------
  in_item_t raw_q[$];
  int       n_queued = 0;
  int       n_taken  = 0;
  bit       no_idle  = 1'b0;  // set for stretches with no idling on either side

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= '0;
      model_reset();
      n_taken = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        unescape_item(in_ch.payload);
        n_taken++;
      end
      // load the next item only when the slot is free, so valid is set once per edge
      if (!in_ch.valid || in_ch.ready) begin
        if (raw_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.payload <= raw_q.pop_front();
          in_ch.valid   <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, plus a long hold-off counted here on request
  // ---------------------------------------------------------------------------
  bit rx_hold_go = 1'b0;
  int hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (rx_hold_go) begin
      out_ch.ready <= 1'b0;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  int        err_cnt = 0;
  out_item_t got_r;
  out_item_t want_r;

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_r = out_ch.payload;
      if (decoded_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result byte %02h valid %b str_end %b run_end %b",
                 $time, got_r.out_byte, got_r.byte_valid, got_r.string_end, got_r.run_end);
      end else begin
        want_r = decoded_q.pop_front();
        if (got_r.out_byte != want_r.out_byte || got_r.byte_valid != want_r.byte_valid ||
            got_r.string_end != want_r.string_end || got_r.run_end != want_r.run_end) begin
          err_cnt++;
          $display("%0t: mismatch exp byte %02h valid %b str_end %b run_end %b",
                   $time, want_r.out_byte, want_r.byte_valid, want_r.string_end,
                   want_r.run_end);
          $display("%0t:          got byte %02h valid %b str_end %b run_end %b",
                   $time, got_r.out_byte, got_r.byte_valid, got_r.string_end, got_r.run_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: strings built from escape segments
  // ---------------------------------------------------------------------------
  logic [7:0] str_q[$];

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + 8'(n);
    else c = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n - 4'd10);  // either case
    return c;
  endfunction

  function automatic logic [7:0] bad_hex();
    logic [7:0] c;
    logic [4:0] v;
    c = 8'(($urandom_range(255)));
    v = nib(c);
    while (!v[4]) begin
      c = 8'(($urandom_range(255)));
      v = nib(c);
    end
    return c;
  endfunction

  function void add_uni(logic [15:0] code);
    str_q.push_back(CH_BSLASH);
    str_q.push_back(CH_U);
    for (int i = 3; i >= 0; i--) str_q.push_back(hex_char(code[i*4 +: 4]));
  endfunction

  function automatic logic [15:0] pick_code(int cls);
    logic [15:0] c;
    case (cls)
      0: c = 16'($urandom_range(16'h7F));
      1: c = 16'($urandom_range(16'h7FF, 16'h80));
      2: c = 16'($urandom_range(16'hFFFF, 16'h800));
      3: c = 16'($urandom_range(16'hDBFF, 16'hD800));
      4: c = 16'($urandom_range(16'hDFFF, 16'hDC00));
      5: c = 16'h0000;
      default: c = 16'hFFFF;
    endcase
    return c;
  endfunction

  function void add_segment();
    logic [7:0] b;
    int         k;
    case ($urandom_range(12))
      0, 1, 2: begin
        // plain bytes, now and then a stray backslash
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++) begin
          b = 8'($urandom_range(255));
          if (b == CH_BSLASH && $urandom_range(3) != 0) b = CH_LZ;
          str_q.push_back(b);
        end
      end
      3: begin
        str_q.push_back(CH_BSLASH);
        case ($urandom_range(7))
          0: str_q.push_back(CH_QUOTE);
          1: str_q.push_back(CH_BSLASH);
          2: str_q.push_back(CH_SLASH);
          3: str_q.push_back(CH_LB);
          4: str_q.push_back(CH_LF);
          5: str_q.push_back(CH_LN);
          6: str_q.push_back(CH_LR);
          default: str_q.push_back(CH_LT);
        endcase
      end
      4: begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back(8'($urandom_range(255)));
      end
      5, 6: add_uni(pick_code($urandom_range(6)));
      7, 8: begin
        add_uni(pick_code(3));
        add_uni(pick_code(4));
      end
      9, 10: begin
        // high surrogate, then a second escape broken at some point
        add_uni(pick_code(3));
        case ($urandom_range(3))
          0: begin
            b = 8'($urandom_range(255));
            if (b == CH_BSLASH) b = CH_LZ;
            str_q.push_back(b);
          end
          1: begin
            b = 8'($urandom_range(255));
            if (b == CH_U) b = CH_LZ;
            str_q.push_back(CH_BSLASH);
            str_q.push_back(b);
          end
          2: begin
            str_q.push_back(CH_BSLASH);
            str_q.push_back(CH_U);
            k = $urandom_range(3);
            for (int i = 0; i < k; i++) str_q.push_back(hex_char(4'($urandom_range(15))));
            str_q.push_back(bad_hex());
          end
          default: add_uni(pick_code($urandom_range(3)));
        endcase
      end
      default: begin
        // first escape broken inside its hex digits
        str_q.push_back(CH_BSLASH);
        str_q.push_back(CH_U);
        k = $urandom_range(3);
        for (int i = 0; i < k; i++) str_q.push_back(hex_char(4'($urandom_range(15))));
        str_q.push_back(bad_hex());
      end
    endcase
  endfunction

  // queues the collected bytes as one string, the final one marked last; with may_cut the tail may be cut off
  function void send_string(bit may_cut);
    in_item_t it;
    int       k;
    if (may_cut && str_q.size() > 1 && $urandom_range(5) == 0) begin
      k = $urandom_range(str_q.size() - 1, 1);
      for (int i = 0; i < k; i++) void'(str_q.pop_back());
    end
    for (int i = 0; i < str_q.size(); i++) begin
      it.in_byte = str_q[i];
      it.in_last = (i == str_q.size() - 1);
      raw_q.push_back(it);
      n_queued++;
    end
    str_q.delete();
  endfunction

  function void random_string();
    int nseg;
    nseg = $urandom_range(5, 1);
    for (int i = 0; i < nseg; i++) add_segment();
    send_string(1'b1);
  endfunction

  // everything sent is accepted and every expected result has come
  task wait_drained();
    while (n_taken != n_queued) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int start_n;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of the byte, a simple escape, then an unknown escape on the last
    // byte, which leaves a bare end marker
    str_q = '{8'h00, 8'hFF, CH_BSLASH, CH_LT, CH_BSLASH, CH_LZ};
    send_string(1'b0);
    // surrogate pair to four utf-8 bytes
    add_uni(16'hD83D);
    add_uni(16'hDE00);
    send_string(1'b0);
    // bad hex early: held bytes raw, then the rest of the six passes raw
    str_q = '{CH_BSLASH, CH_U, CH_ONE, CH_X, CH_BSLASH, CH_LN};
    send_string(1'b0);
    // lone low surrogate, and an escape cut off by the end of the string
    add_uni(16'hDC00);
    send_string(1'b0);
    str_q = '{CH_BSLASH, CH_U, CH_ONE};
    send_string(1'b0);

    // sender waits for every result before going on
    wait_drained();

    // receiver holds off while the sender keeps offering, no idling otherwise
    no_idle = 1'b1;
    start_n = n_queued;
    while (n_queued - start_n < 30) random_string();
    @(posedge clk_i);
    rx_hold_go <= 1'b1;
    @(posedge clk_i);
    rx_hold_go <= 1'b0;
    while (n_taken != n_queued) @(posedge clk_i);
    no_idle = 1'b0;

    // random strings with idling on both sides
    start_n = n_queued;
    while (n_queued - start_n < RAND_ITEMS) random_string();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
